// ===== hdl/form_urlencoded_pair_decoder_unit_defines.svh =====
// Assertion macros for the decoder modules; fupd_decode is the one that uses them.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef FORM_URLENCODED_PAIR_DECODER_UNIT_DEFINES_SVH
`define FORM_URLENCODED_PAIR_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FUPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fupd: same-cycle check failed");

`define FUPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fupd: next-cycle check failed");

`else

`define FUPD_ASSERT_IMP(lbl, ante, cons)

`define FUPD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/fupd_pkg.sv =====
package fupd_pkg;

  localparam logic [7:0] AMP_CHAR = 8'h26;
  localparam logic [7:0] EQ_CHAR  = 8'h3D;
  localparam logic [7:0] PCT_CHAR = 8'h25;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       value_part;
    logic       name_done;
    logic       pair_done;
    logic       missing_equals;
    logic       escape_error;
  } res_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    case (c) inside
      [8'h30:8'h39]:                h.val = c[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: h.val = c[3:0] + 4'd9;
      default:                      h.ok  = 1'b0;
    endcase
    return h;
  endfunction

endpackage

// ===== hdl/form_urlencoded_pair_decoder_unit.sv =====
// Form-urlencoded pair decoder.
// Input channel: one raw byte per request (in_byte, with in_last on the final
// byte of a string), taken on in_valid and in_ready.
// Result channel: at most one result per input byte, offered on result_valid
// and taken on result_ready. A result carries a decoded byte (out_byte with
// out_valid, tagged by in_value_part) and the marks name_done, pair_done,
// missing_equals and escape_error. Bytes that only advance the state, such
// as a percent sign or the first hex digit, give no result.
// A result passes from the input register through the decode logic into the
// result register, which offers it.
// Throughput: one byte per cycle while result_ready stays high.
// When the receiver stalls, the result register holds its request and one
// more byte waits in the input register; in_ready then drops.
// Reset empties both registers and returns the decoder to the state between
// pairs; the byte after a final byte likewise starts a fresh string.
module form_urlencoded_pair_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       in_value_part,
  output logic       name_done,
  output logic       pair_done,
  output logic       missing_equals,
  output logic       escape_error
);

  logic           held;
  logic [7:0]     raw;
  logic           last;
  logic           free;
  logic           fire;
  logic           has_res;
  fupd_pkg::res_t res;
  fupd_pkg::res_t held_res;

  assign fire = held && free;

  fupd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .take     (fire),
    .held     (held),
    .raw      (raw),
    .last     (last)
  );

  fupd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .raw     (raw),
    .last    (last),
    .res     (res),
    .has_res (has_res)
  );

  fupd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire),
    .has_res      (has_res),
    .res          (res),
    .free         (free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .held_res     (held_res)
  );

  assign out_byte       = held_res.data;
  assign out_valid      = held_res.dvalid;
  assign in_value_part  = held_res.value_part;
  assign name_done      = held_res.name_done;
  assign pair_done      = held_res.pair_done;
  assign missing_equals = held_res.missing_equals;
  assign escape_error   = held_res.escape_error;

endmodule

// ===== hdl/fupd_in_stage.sv =====
module fupd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       take,
  output logic       held,
  output logic [7:0] raw,
  output logic       last
);

  logic       held_next;

  // The register refills in the same cycle that its request is taken.
  assign in_ready  = !held || take;
  assign held_next = (in_valid && in_ready) || (held && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw  <= in_byte;
      last <= in_last;
    end
  end

endmodule

// ===== hdl/fupd_decode.sv =====
`include "form_urlencoded_pair_decoder_unit_defines.svh"

module fupd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        raw,
  input  logic              last,
  output fupd_pkg::res_t    res,
  output logic              has_res
);

  fupd_pkg::phase_t phase, phase_next;
  fupd_pkg::esc_t   esc, esc_next;
  logic [3:0]       high_nibble, high_nibble_next;
  fupd_pkg::hex_t   hex;
  logic             closing;

  assign hex = fupd_pkg::hex_decode(raw);

  always_comb begin
    phase_next       = phase;
    esc_next         = esc;
    high_nibble_next = high_nibble;
    res              = '0;
    closing          = 1'b0;

    if (esc != fupd_pkg::ESC_NONE) begin
      if (raw == fupd_pkg::AMP_CHAR) begin
        closing = 1'b1;
      end else if (!hex.ok) begin
        res.escape_error = 1'b1;
        esc_next         = fupd_pkg::ESC_NONE;
        high_nibble_next = 4'd0;
      end else if (esc == fupd_pkg::ESC_HIGH) begin
        high_nibble_next = hex.val;
        esc_next         = fupd_pkg::ESC_LOW;
      end else begin
        res.data         = {high_nibble, hex.val};
        res.dvalid       = 1'b1;
        res.value_part   = (phase == fupd_pkg::PH_VALUE);
        esc_next         = fupd_pkg::ESC_NONE;
        high_nibble_next = 4'd0;
      end
    end else if (raw == fupd_pkg::AMP_CHAR) begin
      // An ampersand between pairs is an empty pair and is dropped.
      closing = (phase != fupd_pkg::PH_IDLE);
    end else if (raw == fupd_pkg::EQ_CHAR && phase != fupd_pkg::PH_VALUE) begin
      res.name_done = 1'b1;
      phase_next    = fupd_pkg::PH_VALUE;
    end else if (raw == fupd_pkg::PCT_CHAR) begin
      if (phase == fupd_pkg::PH_IDLE) begin
        phase_next = fupd_pkg::PH_NAME;
      end
      esc_next = fupd_pkg::ESC_HIGH;
    end else begin
      if (phase == fupd_pkg::PH_IDLE) begin
        phase_next = fupd_pkg::PH_NAME;
      end
      res.data       = raw;
      res.dvalid     = 1'b1;
      res.value_part = (phase == fupd_pkg::PH_VALUE);
    end

    if (last && phase_next != fupd_pkg::PH_IDLE) begin
      closing = 1'b1;
    end

    // Closing a pair with an escape still open is an error too.
    if (closing) begin
      res.escape_error   = res.escape_error || (esc_next != fupd_pkg::ESC_NONE);
      res.pair_done      = 1'b1;
      res.missing_equals = (phase_next == fupd_pkg::PH_NAME);
      phase_next         = fupd_pkg::PH_IDLE;
      esc_next           = fupd_pkg::ESC_NONE;
      high_nibble_next   = 4'd0;
    end

    has_res = res.dvalid || res.name_done || res.pair_done || res.escape_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= fupd_pkg::PH_IDLE;
      esc         <= fupd_pkg::ESC_NONE;
      high_nibble <= 4'd0;
    end else if (fire) begin
      phase       <= phase_next;
      esc         <= esc_next;
      high_nibble <= high_nibble_next;
    end
  end

  `FUPD_ASSERT_IMP(a_esc_in_pair, esc != fupd_pkg::ESC_NONE, phase != fupd_pkg::PH_IDLE)
  `FUPD_ASSERT_IMP(a_nibble_only_low, esc != fupd_pkg::ESC_LOW, high_nibble == 4'd0)
  `FUPD_ASSERT_IMP(a_me_with_pd, fire && res.missing_equals, res.pair_done)
  `FUPD_ASSERT_NXT(a_close_resets, fire && (res.pair_done || last),
                   phase == fupd_pkg::PH_IDLE && esc == fupd_pkg::ESC_NONE)

endmodule

// ===== hdl/fupd_out_stage.sv =====
module fupd_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           has_res,
  input  fupd_pkg::res_t res,
  output logic           free,
  output logic           result_valid,
  input  logic           result_ready,
  output fupd_pkg::res_t held_res
);

  logic result_valid_next;

  assign free = !result_valid || result_ready;

  always_comb begin
    if (load) begin
      result_valid_next = has_res;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && has_res) begin
      held_res <= res;
    end
  end

endmodule

// ===== tb/form_urlencoded_pair_decoder_unit_test.sv =====
module form_urlencoded_pair_decoder_unit_test;

  localparam int DIR_ROWS     = 25;
  localparam int RANDOM_BYTES = 650;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,
    ROW_QUIET   = 2'd1,
    ROW_GIVES   = 2'd2
  } row_kind_t;

  typedef struct packed {
    logic [7:0]     b;
    logic           last;
    row_kind_t      kind;
    fupd_pkg::res_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       result_valid;
  logic       result_ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       in_value_part;
  logic       name_done;
  logic       pair_done;
  logic       missing_equals;
  logic       escape_error;

  // Decoder state as the predictor tracks it.
  fupd_pkg::phase_t dec_phase;
  fupd_pkg::esc_t   dec_esc;
  logic [3:0]       dec_nibble;

  fupd_pkg::res_t decoded_q[$];
  logic [7:0]     chunk_q[$];
  dir_row_t       dir_tab[DIR_ROWS];

  int  mismatches   = 0;
  int  bytes_sent   = 0;
  int  results_seen = 0;
  int  strings_sent = 0;
  int  flagged_seen = 0;
  int  cycle_count  = 0;
  bit  drv_calm     = 1'b0;
  bit  rcv_calm     = 1'b0;

  form_urlencoded_pair_decoder_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .in_value_part  (in_value_part),
    .name_done      (name_done),
    .pair_done      (pair_done),
    .missing_equals (missing_equals),
    .escape_error   (escape_error)
  );

  always #2 clk = ~clk;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // Advances the predicted decoder state by one byte; returns 1 when the
  // byte produces a result.
  function automatic bit decode_step(input logic [7:0] b, input logic last,
                                     output fupd_pkg::res_t r);
    int h;
    bit closing;
    r = '0;
    closing = 1'b0;
    if (dec_esc != fupd_pkg::ESC_NONE) begin
      if (b == fupd_pkg::AMP_CHAR) begin
        closing = 1'b1;
      end else begin
        h = hex_value(b);
        if (h < 0) begin
          r.escape_error = 1'b1;
          dec_esc = fupd_pkg::ESC_NONE;
          dec_nibble = 4'd0;
        end else if (dec_esc == fupd_pkg::ESC_HIGH) begin
          dec_nibble = h[3:0];
          dec_esc = fupd_pkg::ESC_LOW;
        end else begin
          r.data = {dec_nibble, h[3:0]};
          r.dvalid = 1'b1;
          r.value_part = (dec_phase == fupd_pkg::PH_VALUE);
          dec_esc = fupd_pkg::ESC_NONE;
          dec_nibble = 4'd0;
        end
      end
    end else if (b == fupd_pkg::AMP_CHAR) begin
      if (dec_phase != fupd_pkg::PH_IDLE) closing = 1'b1;
    end else if (b == fupd_pkg::EQ_CHAR && dec_phase != fupd_pkg::PH_VALUE) begin
      r.name_done = 1'b1;
      dec_phase = fupd_pkg::PH_VALUE;
    end else if (b == fupd_pkg::PCT_CHAR) begin
      if (dec_phase == fupd_pkg::PH_IDLE) dec_phase = fupd_pkg::PH_NAME;
      dec_esc = fupd_pkg::ESC_HIGH;
    end else begin
      if (dec_phase == fupd_pkg::PH_IDLE) dec_phase = fupd_pkg::PH_NAME;
      r.data = b;
      r.dvalid = 1'b1;
      r.value_part = (dec_phase == fupd_pkg::PH_VALUE);
    end

    if (last && dec_phase != fupd_pkg::PH_IDLE) closing = 1'b1;

    if (closing) begin
      if (dec_esc != fupd_pkg::ESC_NONE) r.escape_error = 1'b1;
      r.pair_done = 1'b1;
      r.missing_equals = (dec_phase == fupd_pkg::PH_NAME);
      dec_phase = fupd_pkg::PH_IDLE;
      dec_esc = fupd_pkg::ESC_NONE;
      dec_nibble = 4'd0;
    end
    return r.dvalid | r.name_done | r.pair_done | r.escape_error;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input row_kind_t kind, input fupd_pkg::res_t want);
    int             gap;
    bit             gives;
    fupd_pkg::res_t pred;
    gap = drv_calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    gives = decode_step(b, last, pred);
    if (kind == ROW_GIVES) begin
      decoded_q.push_back(want);
    end else if (kind == ROW_PREDICT && gives) begin
      decoded_q.push_back(pred);
    end
    bytes_sent++;
    if (bytes_sent % 40 == 0) drv_calm = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("A" + k - 10);
    return 8'("a" + k - 16);
  endfunction

  function automatic void add_token();
    int k;
    int j;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2: chunk_q.push_back(8'("a" + $urandom_range(0, 25)));
      3:       chunk_q.push_back(8'("0" + $urandom_range(0, 9)));
      4:       chunk_q.push_back(8'($urandom_range(0, 255)));
      5, 6, 7: begin
        chunk_q.push_back(fupd_pkg::PCT_CHAR);
        chunk_q.push_back(hex_char());
        chunk_q.push_back(hex_char());
      end
      8:       chunk_q.push_back("+");
      default: begin
        // A bare or half escape, left to whatever byte follows it.
        chunk_q.push_back(fupd_pkg::PCT_CHAR);
        j = $urandom_range(0, 2);
        if (j >= 1) chunk_q.push_back(hex_char());
        if (j == 2) chunk_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  task automatic send_random_string();
    int npairs;
    int p;
    int k;
    int j;
    chunk_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(1, 8);
      repeat (k) chunk_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      npairs = $urandom_range(1, 4);
      for (p = 0; p < npairs; p++) begin
        if ($urandom_range(0, 7) == 0) chunk_q.push_back(fupd_pkg::AMP_CHAR);
        k = $urandom_range(0, 4);
        repeat (k) add_token();
        if ($urandom_range(0, 7) != 0) begin
          chunk_q.push_back(fupd_pkg::EQ_CHAR);
          k = $urandom_range(0, 4);
          repeat (k) add_token();
        end
        if (p != npairs - 1 || $urandom_range(0, 3) == 0) begin
          chunk_q.push_back(fupd_pkg::AMP_CHAR);
        end
      end
    end
    if (chunk_q.size() == 0) chunk_q.push_back(8'($urandom_range(0, 255)));
    for (j = 0; j < chunk_q.size(); j++) begin
      send_byte(chunk_q[j], (j == chunk_q.size() - 1), ROW_PREDICT, '0);
    end
    strings_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, decoded_q.size());
      $display("[form_urlencoded_pair_decoder_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    fupd_pkg::res_t got;
    fupd_pkg::res_t want;
    if (!rst && result_valid && result_ready) begin
      got = {out_byte, out_valid, in_value_part, name_done, pair_done,
             missing_equals, escape_error};
      results_seen++;
      if (got.escape_error || got.missing_equals) flagged_seen++;
      if (results_seen % 40 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
      if (decoded_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: byte=%h valid=%b value=%b nd=%b pd=%b me=%b ee=%b",
                   got.data, got.dvalid, got.value_part, got.name_done,
                   got.pair_done, got.missing_equals, got.escape_error);
        end
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("result %0d mismatch:", results_seen);
            $display("  expected byte=%h valid=%b value=%b nd=%b pd=%b me=%b ee=%b",
                     want.data, want.dvalid, want.value_part, want.name_done,
                     want.pair_done, want.missing_equals, want.escape_error);
            $display("  actual   byte=%h valid=%b value=%b nd=%b pd=%b me=%b ee=%b",
                     got.data, got.dvalid, got.value_part, got.name_done,
                     got.pair_done, got.missing_equals, got.escape_error);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rcv_calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  initial begin
    int i;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    in_last  = 1'b0;
    dec_phase  = fupd_pkg::PH_IDLE;
    dec_esc    = fupd_pkg::ESC_NONE;
    dec_nibble = 4'd0;

    // Row layout: byte, last, kind, then the result as data followed by
    // the flags valid, value, name_done, pair_done, missing_equals, escape_error.
    dir_tab[0]  = {"a",     1'b0, ROW_GIVES,   8'h61, 6'b100000};
    dir_tab[1]  = {"=",     1'b0, ROW_GIVES,   8'h00, 6'b001000};
    dir_tab[2]  = {"b",     1'b0, ROW_GIVES,   8'h62, 6'b110000};
    dir_tab[3]  = {"=",     1'b0, ROW_GIVES,   8'h3D, 6'b110000};
    dir_tab[4]  = {"&",     1'b0, ROW_GIVES,   8'h00, 6'b000100};
    // An ampersand between pairs is an empty pair and stays silent.
    dir_tab[5]  = {"&",     1'b0, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[6]  = {"%",     1'b0, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[7]  = {"F",     1'b0, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[8]  = {"f",     1'b0, ROW_GIVES,   8'hFF, 6'b100000};
    dir_tab[9]  = {"%",     1'b0, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[10] = {"0",     1'b0, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[11] = {"0",     1'b0, ROW_GIVES,   8'h00, 6'b100000};
    dir_tab[12] = {"+",     1'b0, ROW_PREDICT, 8'h00, 6'b000000};
    dir_tab[13] = {"&",     1'b0, ROW_GIVES,   8'h00, 6'b000110};
    dir_tab[14] = {"=",     1'b0, ROW_GIVES,   8'h00, 6'b001000};
    dir_tab[15] = {"%",     1'b0, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[16] = {"g",     1'b0, ROW_GIVES,   8'h00, 6'b000001};
    dir_tab[17] = {"%",     1'b0, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[18] = {"&",     1'b0, ROW_GIVES,   8'h00, 6'b000101};
    dir_tab[19] = {8'h00,   1'b0, ROW_PREDICT, 8'h00, 6'b000000};
    dir_tab[20] = {"%",     1'b0, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[21] = {"A",     1'b1, ROW_GIVES,   8'h00, 6'b000111};
    dir_tab[22] = {8'hFF,   1'b1, ROW_GIVES,   8'hFF, 6'b100110};
    dir_tab[23] = {"&",     1'b1, ROW_QUIET,   8'h00, 6'b000000};
    dir_tab[24] = {"=",     1'b1, ROW_GIVES,   8'h00, 6'b001100};

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].kind, dir_tab[i].want);
    end
    while (bytes_sent < DIR_ROWS + RANDOM_BYTES) send_random_string();
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d random strings) and checked %0d results,",
             bytes_sent, strings_sent, results_seen);
    $display("%0d of them carrying escape or missing-equals flags; %0d mismatches",
             flagged_seen, mismatches);
    if (mismatches == 0) begin
      $display("[form_urlencoded_pair_decoder_unit] OK");
    end else begin
      $display("[form_urlencoded_pair_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
